/* sv/handle_slot_allocator_macros.svh */
// assertion macros for the handle slot allocator checker
`ifndef HANDLE_SLOT_ALLOCATOR_MACROS_SVH
`define HANDLE_SLOT_ALLOCATOR_MACROS_SVH

// clocked assertion, disabled while reset is high
`define HSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define HSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/hsa_pkg.sv */
// shared constants for the handle slot allocator
package hsa_pkg;

   localparam int HANDLE_W = 31;
   localparam int VALUE_W  = 31;
   localparam int RESULT_W = 32;

   localparam logic [HANDLE_W-1:0] BASE_RESET = 31'd100000;

   // request codes
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_FREE   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;

endpackage

/* sv/hsa_ram.sv */
// generic single-port-write ram with registered read
module hsa_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/hsa_first_free.sv */
// lowest free slot finder over the in-use vector
module hsa_first_free #(
   parameter int SLOTS = 64,
   parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic [SLOTS-1:0] free_vec,
   output logic             found,
   output logic [IDX_W-1:0] idx
);

   logic [SLOTS-1:0] lowest;

   // isolate the lowest set bit, then encode it
   assign lowest = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});
   assign found  = |free_vec;

   always_comb begin
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         for (int j = 0; j < IDX_W; j++) begin
            if (((i >> j) & 1) != 0) begin
               idx[j] = idx[j] | lowest[i];
            end
         end
      end
   end

endmodule

/* sv/handle_slot_allocator.sv */
// handle slot allocator top level
//
// Maps local handles to stored remote values through a fixed table of SLOTS slots.
// req channel (valid/ready): req_type selects allocate, look up or free;
// req_handle names the handle for look up and free; req_store_value is
// recorded by allocate. rsp channel (valid/ready) returns one transaction per
// request: rsp_status, rsp_new_handle, rsp_is_mapped, rsp_mapped_value.
// csr_we with csr_wdata sets the handle of slot zero; write it only while idle.
// A request is held in the input stage, then its result is offered from the result register.
// Throughput: one request per cycle unless the receiver stalls, set by the lowest-free-slot
// encoder over the in-use bits and the single read port of the slot value ram.
// Reset: every slot is free and the handle base is 100000. Slot values need
// no clearing pass, since a value is read only from a slot in use.
// When the receiver stalls, the result register holds and one more request
// can sit in the input stage; req_ready drops only when both are full.
module handle_slot_allocator
   import hsa_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_type,
   input  logic [HANDLE_W-1:0]        req_handle,
   input  logic [VALUE_W-1:0]         req_store_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [HANDLE_W-1:0]        rsp_new_handle,
   output logic                       rsp_is_mapped,
   output logic signed [RESULT_W-1:0] rsp_mapped_value,
   input  logic                       csr_we,
   input  logic [HANDLE_W-1:0]        csr_wdata
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [HANDLE_W-1:0] base_ff;
   logic [SLOTS-1:0]    used_ff, used_in;

   // input stage
   logic                a_vld_ff, a_vld_in;
   logic [1:0]          a_type_ff;
   logic                a_range_ff;
   logic [IDX_W-1:0]    a_off_ff;
   logic [VALUE_W-1:0]  a_value_ff;
   logic                byp_vld_ff, byp_vld_in;
   logic [VALUE_W-1:0]  byp_val_ff;

   // result stage
   logic                r_vld_ff, r_vld_in;
   logic [1:0]          r_status_ff, r_status_in;
   logic [HANDLE_W-1:0] r_new_handle_ff, r_new_handle_in;
   logic                r_mapped_ff, r_mapped_in;
   logic [RESULT_W-1:0] r_value_ff, r_value_in;

   logic                req_acc, a_adv;
   logic [RESULT_W-1:0] in_diff;
   logic                in_range;
   logic [IDX_W-1:0]    in_off;
   logic                ff_found;
   logic [IDX_W-1:0]    ff_idx;
   logic                a_used;
   logic                wr_en;
   logic                clr_en;
   logic [VALUE_W-1:0]  ram_rdata, rd_value;

   assign a_adv     = a_vld_ff && (!r_vld_ff || rsp_ready);
   assign req_ready = !a_vld_ff || !r_vld_ff || rsp_ready;
   assign req_acc   = req_valid && req_ready;

   // offset of the handle from the base; top bit set means below the base
   assign in_diff  = {1'b0, req_handle} - {1'b0, base_ff};
   assign in_range = !in_diff[RESULT_W-1] && (in_diff[HANDLE_W-1:0] < HANDLE_W'(SLOTS));
   assign in_off   = in_diff[IDX_W-1:0];

   hsa_first_free #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_first_free (
      .free_vec (~used_ff),
      .found    (ff_found),
      .idx      (ff_idx)
   );

   hsa_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS), .ADDR_W(IDX_W)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ff_idx),
      .wr_data (a_value_ff),
      .rd_en   (req_acc && in_range),
      .rd_addr (in_off),
      .rd_data (ram_rdata)
   );

   assign a_used   = a_range_ff && used_ff[a_off_ff];
   assign rd_value = byp_vld_ff ? byp_val_ff : ram_rdata;

   always_comb begin
      r_status_in     = ST_OK;
      r_new_handle_in = '0;
      r_mapped_in     = 1'b0;
      r_value_in      = '1;
      wr_en           = 1'b0;
      clr_en          = 1'b0;
      case (a_type_ff)
         REQ_ALLOC: begin
            if (ff_found) begin
               r_new_handle_in = base_ff + HANDLE_W'(ff_idx);
               wr_en           = a_adv;
            end else begin
               r_status_in = ST_FULL;
            end
         end
         REQ_LOOKUP: begin
            if (a_used) begin
               r_mapped_in = 1'b1;
               r_value_in  = {1'b0, rd_value};
            end else begin
               r_status_in = ST_NOT_MAPPED;
            end
         end
         REQ_FREE: begin
            if (a_used) begin
               r_mapped_in = 1'b1;
               clr_en      = a_adv;
            end else begin
               r_status_in = ST_NOT_MAPPED;
            end
         end
         default: begin
            r_status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      used_in = used_ff;
      if (wr_en) begin
         used_in[ff_idx] = 1'b1;
      end
      if (clr_en) begin
         used_in[a_off_ff] = 1'b0;
      end
   end

   // a lookup read at the same edge as an allocate write misses it in the ram
   assign byp_vld_in = wr_en && in_range && (in_off == ff_idx);
   assign a_vld_in   = req_acc || (a_vld_ff && !a_adv);
   assign r_vld_in   = a_adv || (r_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_RESET;
         used_ff    <= '0;
         a_vld_ff   <= 1'b0;
         r_vld_ff   <= 1'b0;
         byp_vld_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         used_ff  <= used_in;
         a_vld_ff <= a_vld_in;
         r_vld_ff <= r_vld_in;
         if (req_acc) begin
            byp_vld_ff <= byp_vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_type_ff  <= req_type;
         a_range_ff <= in_range;
         a_off_ff   <= in_off;
         a_value_ff <= req_store_value;
         byp_val_ff <= a_value_ff;
      end
      if (a_adv) begin
         r_status_ff     <= r_status_in;
         r_new_handle_ff <= r_new_handle_in;
         r_mapped_ff     <= r_mapped_in;
         r_value_ff      <= r_value_in;
      end
   end

   assign rsp_valid        = r_vld_ff;
   assign rsp_status       = r_status_ff;
   assign rsp_new_handle   = r_new_handle_ff;
   assign rsp_is_mapped    = r_mapped_ff;
   assign rsp_mapped_value = r_value_ff;

endmodule

/* sv/hsa_checker.sv */
// port-level checker for the handle slot allocator, with its bind
`include "handle_slot_allocator_macros.svh"

module hsa_checker
   import hsa_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic [HANDLE_W-1:0]        rsp_new_handle,
   input logic                       rsp_is_mapped,
   input logic signed [RESULT_W-1:0] rsp_mapped_value
);

   // a stalled result transaction holds
   `HSA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_new_handle) && $stable(rsp_mapped_value), "stalled result changed")

   // no result is offered right after reset
   `HSA_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // with the result register empty the input side must take a transaction
   `HSA_ASSERT(a_ready_empty, clock, reset, !rsp_valid |-> req_ready, "ready low with empty output")

   // a full table gives no handle, no mapping and the all-ones value
   `HSA_ASSERT(a_full_fields, clock, reset, rsp_valid && rsp_status == ST_FULL |-> rsp_new_handle == '0 && !rsp_is_mapped && rsp_mapped_value == 32'hFFFF_FFFF, "table full result fields wrong")

   // a mapped handle always reports ok
   `HSA_ASSERT(a_mapped_ok, clock, reset, rsp_valid && rsp_is_mapped |-> rsp_status == ST_OK && rsp_new_handle == '0, "mapped result with bad status")

endmodule

bind handle_slot_allocator hsa_checker u_hsa_checker (.*);
